>>> design/spp_pkg.sv
// Shared types and constants for the segment point projection block
`default_nettype none
package spp_pkg;

  localparam int unsigned CoordW = 32;          // Q16.16 coordinate
  localparam int unsigned DiffW  = 33;          // coordinate difference
  localparam int unsigned ProdW  = 66;          // 33x33 signed product
  localparam int unsigned L2W    = 67;          // squared length / dot magnitude
  localparam int unsigned QuotW  = 32;          // t fraction
  localparam int unsigned RadW   = 66;          // squared distance
  localparam int unsigned RootW  = 34;          // root bits 33..0
  localparam int unsigned GapW   = 33;
  localparam logic [GapW-1:0] GapMax = {GapW{1'b1}};

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_A_X = 3'd0,
    CFG_A_Y = 3'd1,
    CFG_A_Z = 3'd2,
    CFG_B_X = 3'd3,
    CFG_B_Y = 3'd4,
    CFG_B_Z = 3'd5,
    CFG_TOL = 3'd6
  } cfg_reg_e;

  // which point the result takes
  typedef enum logic [1:0] {
    SEL_A   = 2'd0,
    SEL_B   = 2'd1,
    SEL_MIX = 2'd2
  } sel_e;

  // data travelling alongside the divider
  typedef struct packed {
    logic [2:0][CoordW-1:0] a;
    logic [2:0][CoordW-1:0] b;
    logic [2:0][CoordW-1:0] p;
    logic [2:0][DiffW-1:0]  d;
    sel_e                   sel;
  } div_side_t;

  // data travelling alongside the square root
  typedef struct packed {
    logic [2:0][CoordW-1:0] nr;
  } sqrt_side_t;

endpackage
`default_nettype wire

>>> design/spp_div.sv
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module spp_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [spp_pkg::L2W-1:0]    dot_i,
  input  wire logic [spp_pkg::L2W-1:0]    l2_i,
  input  wire spp_pkg::div_side_t         side_i,
  output logic                            valid_o,
  output logic [spp_pkg::QuotW-1:0]       quot_o,
  output spp_pkg::div_side_t              side_o
);

  localparam int unsigned N = spp_pkg::QuotW;

  logic                       valid_q [1:N];
  logic [spp_pkg::L2W-1:0]    rem_q   [1:N];
  logic [spp_pkg::L2W-1:0]    l2_q    [1:N];
  logic [spp_pkg::QuotW-1:0]  quot_q  [1:N];
  spp_pkg::div_side_t         side_q  [1:N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                       v_in;
    logic [spp_pkg::L2W-1:0]    r_in;
    logic [spp_pkg::L2W-1:0]    l_in;
    logic [spp_pkg::QuotW-1:0]  q_in;
    spp_pkg::div_side_t         s_in;
    logic [spp_pkg::L2W:0]      r2;
    logic [spp_pkg::L2W:0]      diff;
    logic                       take;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = dot_i;
      assign l_in = l2_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_rest
      assign v_in = valid_q[s];
      assign r_in = rem_q[s];
      assign l_in = l2_q[s];
      assign q_in = quot_q[s];
      assign s_in = side_q[s];
    end

    // shift remainder, subtract divisor where it fits
    assign r2   = {r_in, 1'b0};
    assign diff = r2 - {1'b0, l_in};
    assign take = (r2 >= {1'b0, l_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? diff[spp_pkg::L2W-1:0] : r2[spp_pkg::L2W-1:0];
        quot_q[s+1] <= {q_in[spp_pkg::QuotW-2:0], take};
        l2_q[s+1]   <= l_in;
        side_q[s+1] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[N];
  assign quot_o  = quot_q[N];
  assign side_o  = side_q[N];

endmodule
`default_nettype wire

>>> design/spp_sqrt.sv
// Pipelined integer square root, one root bit per stage
`default_nettype none
module spp_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [spp_pkg::RadW-1:0]   rad_i,
  input  wire spp_pkg::sqrt_side_t        side_i,
  output logic                            valid_o,
  output logic [spp_pkg::RootW-1:0]       root_o,
  output spp_pkg::sqrt_side_t             side_o
);

  localparam int unsigned N  = spp_pkg::RootW;
  localparam int unsigned TW = 2 * spp_pkg::RootW;

  logic                       valid_q [1:N];
  logic [spp_pkg::RadW-1:0]   rem_q   [1:N];
  logic [spp_pkg::RootW-1:0]  root_q  [1:N];
  spp_pkg::sqrt_side_t        side_q  [1:N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned K = N - 1 - s;
    logic                       v_in;
    logic [spp_pkg::RadW-1:0]   r_in;
    logic [spp_pkg::RootW-1:0]  q_in;
    spp_pkg::sqrt_side_t        s_in;
    logic [TW-1:0]              trial;
    logic [TW-1:0]              rem_w;
    logic                       take;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = rad_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_rest
      assign v_in = valid_q[s];
      assign r_in = rem_q[s];
      assign q_in = root_q[s];
      assign s_in = side_q[s];
    end

    // trial = (2*root + 2^K) * 2^K
    assign trial = ({{(TW-N){1'b0}}, q_in} << (K + 1)) | ({{(TW-1){1'b0}}, 1'b1} << (2 * K));
    assign rem_w = {{(TW-spp_pkg::RadW){1'b0}}, r_in};
    assign take  = (trial <= rem_w);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? spp_pkg::RadW'(rem_w - trial) : r_in;
        root_q[s+1] <= take ? (q_in | (spp_pkg::RootW'(1) << K)) : q_in;
        side_q[s+1] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[N];
  assign root_o  = root_q[N];
  assign side_o  = side_q[N];

endmodule
`default_nettype wire

>>> design/segment_point_projection.sv
// Top level: closest point on a configured 3D segment, fully pipelined
//
// Each query point P (signed Q16.16) yields the point of segment AB nearest
// to P and the distance |P - near| (unsigned Q17.16, floor of the root).
// One transaction is accepted every clock unless a result is stalled at the
// output; on its way from input to output register it passes four front
// stages (differences, products, sums, classification), a 32-stage divider
// producing t one bit per stage, three interpolation/difference stages, one
// squaring stage, one sum stage, a 34-stage square root and the output
// register. The whole pipe halts while a result waits at the output.
// Endpoints and tolerance are written through the configuration port (always
// ready) and must only change while no transaction is in flight.
`default_nettype none
module segment_point_projection (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] point_z_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      near_x_o,
  output logic [31:0]      near_y_o,
  output logic [31:0]      near_z_o,
  output logic [32:0]      gap_length_o
);

  localparam int unsigned CW = spp_pkg::CoordW;
  localparam int unsigned DW = spp_pkg::DiffW;
  localparam int unsigned PW = spp_pkg::ProdW;
  localparam int unsigned LW = spp_pkg::L2W;

  // configuration registers
  logic [2:0][CW-1:0] a_q, b_q;
  logic [CW-1:0]      tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      b_q   <= '0;
      tol_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spp_pkg::CFG_A_X: a_q[0] <= cfg_data_i;
        spp_pkg::CFG_A_Y: a_q[1] <= cfg_data_i;
        spp_pkg::CFG_A_Z: a_q[2] <= cfg_data_i;
        spp_pkg::CFG_B_X: b_q[0] <= cfg_data_i;
        spp_pkg::CFG_B_Y: b_q[1] <= cfg_data_i;
        spp_pkg::CFG_B_Z: b_q[2] <= cfg_data_i;
        spp_pkg::CFG_TOL: tol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless a result is stuck at the output
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  logic [2:0][CW-1:0] pin;
  assign pin = {point_z_i, point_y_i, point_x_i};

  // stage 1: differences D = B - A, E = P - A
  logic               v1_q;
  logic [2:0][CW-1:0] a1_q, b1_q, p1_q;
  logic [2:0][DW-1:0] d1_q, e1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q <= a_q;
      b1_q <= b_q;
      p1_q <= pin;
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= {b_q[i][CW-1], b_q[i]} - {a_q[i][CW-1], a_q[i]};
        e1_q[i] <= {pin[i][CW-1], pin[i]} - {a_q[i][CW-1], a_q[i]};
      end
    end
  end

  // stage 2: products D.D and E.D per axis
  logic               v2_q;
  logic [2:0][CW-1:0] a2_q, b2_q, p2_q;
  logic [2:0][DW-1:0] d2_q;
  logic [2:0][PW-1:0] dd2_q, ed2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q <= a1_q;
      b2_q <= b1_q;
      p2_q <= p1_q;
      d2_q <= d1_q;
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= PW'($signed(d1_q[i]) * $signed(d1_q[i]));
        ed2_q[i] <= PW'($signed(e1_q[i]) * $signed(d1_q[i]));
      end
    end
  end

  // stage 3: squared length and signed dot product
  logic               v3_q;
  logic [2:0][CW-1:0] a3_q, b3_q, p3_q;
  logic [2:0][DW-1:0] d3_q;
  logic [LW-1:0]      l2_3_q;
  logic [LW:0]        dot3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      p3_q   <= p2_q;
      d3_q   <= d2_q;
      l2_3_q <= {1'b0, dd2_q[0]} + {1'b0, dd2_q[1]} + {1'b0, dd2_q[2]};
      dot3_q <= {{2{ed2_q[0][PW-1]}}, ed2_q[0]} + {{2{ed2_q[1][PW-1]}}, ed2_q[1]}
              + {{2{ed2_q[2][PW-1]}}, ed2_q[2]};
    end
  end

  // stage 4: classify into A, B or interpolation
  logic               v4_q;
  spp_pkg::div_side_t side4_q;
  logic [LW-1:0]      l2_4_q, dot4_q;
  spp_pkg::sel_e      sel_d;

  always_comb begin
    if (l2_3_q <= {{(LW-CW){1'b0}}, tol_q}) begin
      sel_d = spp_pkg::SEL_A;
    end else if (dot3_q[LW]) begin
      sel_d = spp_pkg::SEL_A;
    end else if (dot3_q[LW-1:0] >= l2_3_q) begin
      sel_d = spp_pkg::SEL_B;
    end else begin
      sel_d = spp_pkg::SEL_MIX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q.a   <= a3_q;
      side4_q.b   <= b3_q;
      side4_q.p   <= p3_q;
      side4_q.d   <= d3_q;
      side4_q.sel <= sel_d;
      l2_4_q      <= l2_3_q;
      dot4_q      <= dot3_q[LW-1:0];
    end
  end

  // t = floor(dot * 2^32 / L2)
  logic                      vdiv;
  logic [spp_pkg::QuotW-1:0] t_w;
  spp_pkg::div_side_t        sdiv;

  spp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .dot_i   (dot4_q),
    .l2_i    (l2_4_q),
    .side_i  (side4_q),
    .valid_o (vdiv),
    .quot_o  (t_w),
    .side_o  (sdiv)
  );

  // stage 5: D * t per axis
  logic               v5_q;
  spp_pkg::div_side_t side5_q;
  logic [2:0][PW-1:0] dt5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= vdiv;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q <= sdiv;
      for (int i = 0; i < 3; i++) begin
        dt5_q[i] <= PW'($signed(sdiv.d[i]) * $signed({1'b0, t_w}));
      end
    end
  end

  // stage 6: pick the nearest point; floor(D*t/2^32) is bits 63:32
  logic               v6_q;
  logic [2:0][CW-1:0] nr6_q, p6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p6_q <= side5_q.p;
      for (int i = 0; i < 3; i++) begin
        case (side5_q.sel)
          spp_pkg::SEL_B:   nr6_q[i] <= side5_q.b[i];
          spp_pkg::SEL_MIX: nr6_q[i] <= side5_q.a[i] + dt5_q[i][2*CW-1:CW];
          default:          nr6_q[i] <= side5_q.a[i];
        endcase
      end
    end
  end

  // stage 7: P - near
  logic               v7_q;
  logic [2:0][CW-1:0] nr7_q;
  logic [2:0][DW-1:0] g7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (adv) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nr7_q <= nr6_q;
      for (int i = 0; i < 3; i++) begin
        g7_q[i] <= {p6_q[i][CW-1], p6_q[i]} - {nr6_q[i][CW-1], nr6_q[i]};
      end
    end
  end

  // stage 8: squares
  logic               v8_q;
  logic [2:0][CW-1:0] nr8_q;
  logic [2:0][PW-1:0] sq8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (adv) v8_q <= v7_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nr8_q <= nr7_q;
      for (int i = 0; i < 3; i++) begin
        sq8_q[i] <= PW'($signed(g7_q[i]) * $signed(g7_q[i]));
      end
    end
  end

  // stage 9: squared distance (below 3 * 2^64, fits 66 bits)
  logic                      v9_q;
  spp_pkg::sqrt_side_t       side9_q;
  logic [spp_pkg::RadW-1:0]  rad9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (adv) v9_q <= v8_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side9_q.nr <= nr8_q;
      rad9_q     <= spp_pkg::RadW'(sq8_q[0] + sq8_q[1] + sq8_q[2]);
    end
  end

  logic                      vsq;
  logic [spp_pkg::RootW-1:0] root_w;
  spp_pkg::sqrt_side_t       ssq;

  spp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v9_q),
    .rad_i   (rad9_q),
    .side_i  (side9_q),
    .valid_o (vsq),
    .root_o  (root_w),
    .side_o  (ssq)
  );

  // output register with saturation of the distance
  logic [2:0][CW-1:0]       nr_out_q;
  logic [spp_pkg::GapW-1:0] gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= vsq;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nr_out_q <= ssq.nr;
      gap_q    <= root_w[spp_pkg::RootW-1] ? spp_pkg::GapMax : root_w[spp_pkg::GapW-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign near_x_o     = nr_out_q[0];
  assign near_y_o     = nr_out_q[1];
  assign near_z_o     = nr_out_q[2];
  assign gap_length_o = gap_q;

endmodule
`default_nettype wire

>>> design/spp_checker.sv
// Port-level checker for the segment point projection block, with its bind
`default_nettype none
module spp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [31:0] cfg_data_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [31:0] point_x_i,
  input wire logic [31:0] point_y_i,
  input wire logic [31:0] point_z_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] near_x_o,
  input wire logic [31:0] near_y_o,
  input wire logic [31:0] near_z_o,
  input wire logic [32:0] gap_length_o
);

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

  // input only blocks behind a stalled result
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // a stalled result keeps its transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(near_x_o) && $stable(near_y_o)
      && $stable(near_z_o) && $stable(gap_length_o)))
    else $error("result changed while stalled");

endmodule

bind segment_point_projection spp_checker u_spp_checker (.*);
`default_nettype wire
